[rtl/core/first_fit_block_allocator_unit_defines.svh]
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ffba_pkg.sv]
// Shared constants and controller/datapath interface types for the allocator.
package ffba_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_LOG   = 6;
    localparam int CHUNK_BITS = 8;
    localparam int CHUNK_LOG  = 3;
    localparam int CHUNKS     = WORD_BITS / CHUNK_BITS;
    localparam int SIZE_W     = 11;
    localparam int FBASE_W    = 10;
    localparam int BASE_W     = 10;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_command;

    typedef struct packed {
        logic load_req;
        logic clr_wr;
        logic rel_init;
        logic scan_init;
        logic scan_step;
        logic mark_rd;
        logic mark_wr;
        logic res_grant;
        logic res_refuse;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_release;
        logic is_suspended;
        logic alloc_void;
        logic found;
        logic scan_last;
        logic mark_done;
    } t_dp_sts;

endpackage

[rtl/core/ffba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ffba_ctrl.sv]
// Sequencer for clearing, scanning, marking and result handoff.
`include "first_fit_block_allocator_unit_defines.svh"

module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_DECIDE  = 8'b0000_0100,
        S_SCAN    = 8'b0000_1000,
        S_MARK_RD = 8'b0001_0000,
        S_MARK_WR = 8'b0010_0000,
        S_FINISH  = 8'b0100_0000,
        S_SPARE   = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_req = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.is_release) begin
                    w_cmd.rel_init = 1'b1;
                    n_state        = S_MARK_RD;
                end else if (i_sts.is_suspended) begin
                    w_cmd.res_grant = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_sts.alloc_void) begin
                    w_cmd.res_refuse = 1'b1;
                    n_state          = S_FINISH;
                end else begin
                    w_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                priority if (i_sts.found) begin
                    n_state = S_MARK_RD;
                end else if (i_sts.scan_last) begin
                    w_cmd.res_refuse = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_MARK_RD: begin
                if (i_sts.mark_done) begin
                    n_state = S_FINISH;
                end else begin
                    w_cmd.mark_rd = 1'b1;
                    n_state       = S_MARK_WR;
                end
            end
            S_MARK_WR: begin
                w_cmd.mark_wr = 1'b1;
                n_state       = S_MARK_RD;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SPARE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `FFBA_ASSERT_NEXT(a_finish_holds, i_clk, i_rst_n, (r_state == S_FINISH) && r_out_valid && !i_out_ready, r_state == S_FINISH, "result overwrote a pending transaction")
    `FFBA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, (r_state == S_DECIDE) && !o_in_ready, "accepted transaction did not start work")

endmodule

[rtl/core/ffba_dpath.sv]
// Bitmap datapath: request registers, run scan, run marking, result registers.
`include "first_fit_block_allocator_unit_defines.svh"

module ffba_dpath
    import ffba_pkg::*;
#(
    parameter int POOL_UNITS     = 1024,
    parameter int RESERVED_UNITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_command,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic               i_low_priority,
    input  logic               i_suspended,
    input  logic [FBASE_W-1:0] i_free_base,
    output logic               o_granted,
    output logic [BASE_W-1:0]  o_base
);
    localparam int UW     = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
    localparam int EW     = ((UW > SIZE_W) ? UW : SIZE_W) + 1;
    localparam int PRW    = EW - WORD_LOG;
    localparam int ROWS   = (POOL_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [EW-1:0]  POOL_E   = EW'(POOL_UNITS);
    localparam logic [EW-1:0]  RESV_E   = EW'(RESERVED_UNITS);
    localparam logic [PRW-1:0] LAST_ROW = PRW'(ROWS - 1);
    localparam logic [RW-1:0]  LAST_CLR = RW'(ROWS - 1);

    // request
    t_command           r_cmd;
    logic [SIZE_W-1:0]  r_size;
    logic               r_lowp;
    logic               r_susp;
    logic [FBASE_W-1:0] r_fbase;

    // scan and mark
    logic [PRW-1:0]       r_row;
    logic [CHUNK_LOG-1:0] r_chunk;
    logic [SIZE_W-1:0]    r_run;
    logic [EW-1:0]        r_start;
    logic [EW-1:0]        r_lo;
    logic [EW-1:0]        r_ptr;
    logic [EW-1:0]        r_end;
    logic                 r_val;
    logic [RW-1:0]        r_clr_row;

    // result
    logic               r_res_grant;
    logic [BASE_W-1:0]  r_res_base;
    logic               r_granted;
    logic [BASE_W-1:0]  r_base;

    logic [WORD_BITS-1:0]  w_rdata;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [WORD_BITS-1:0]  w_mask;
    logic [CHUNK_BITS-1:0] w_bits;
    logic [CHUNK_BITS-1:0] w_free;
    logic [EW-1:0]         w_unit [CHUNK_BITS];
    logic [EW-1:0]         w_chunk_base;
    logic [EW-1:0]         w_lo_full;
    logic [PRW-1:0]        w_next_row;
    logic [PRW-1:0]        w_ptr_row;
    logic [PRW-1:0]        w_end_row;
    logic [SIZE_W-1:0]     w_run_next;
    logic [EW-1:0]         w_start_next;
    logic                  w_hit;
    logic [EW-1:0]         w_hit_base;
    logic                  w_chunk_last;
    logic                  w_we;
    logic [RW-1:0]         w_waddr;
    logic                  w_re;
    logic [RW-1:0]         w_raddr;

    assign w_lo_full    = r_lowp ? RESV_E : '0;
    assign w_next_row   = r_row + PRW'(1);
    assign w_ptr_row    = r_ptr[EW-1:WORD_LOG];
    assign w_end_row    = r_end[EW-1:WORD_LOG];
    assign w_chunk_last = (r_chunk == CHUNK_LOG'(CHUNKS - 1));
    assign w_chunk_base = {r_row, r_chunk, {CHUNK_LOG{1'b0}}};
    assign w_bits       = w_rdata[CHUNK_BITS*r_chunk +: CHUNK_BITS];

    // units below the search floor or past the pool end count as used
    always_comb begin
        for (int k = 0; k < CHUNK_BITS; k++) begin
            w_unit[k] = w_chunk_base + EW'(k);
            w_free[k] = !w_bits[k] && (w_unit[k] >= r_lo) && (w_unit[k] < POOL_E);
        end
    end

    // walk the chunk one unit at a time, stop at the first run that fits
    always_comb begin
        logic [SIZE_W-1:0] run_v;
        logic [EW-1:0]     start_v;
        logic              hit_v;
        logic [EW-1:0]     base_v;
        run_v   = r_run;
        start_v = r_start;
        hit_v   = 1'b0;
        base_v  = r_start;
        for (int k = 0; k < CHUNK_BITS; k++) begin
            if (!hit_v) begin
                if (!w_free[k]) begin
                    run_v   = '0;
                    start_v = w_unit[k] + EW'(1);
                end else begin
                    run_v = run_v + SIZE_W'(1);
                end
                if (run_v == r_size) begin
                    hit_v  = 1'b1;
                    base_v = start_v;
                end
            end
        end
        w_run_next   = run_v;
        w_start_next = start_v;
        w_hit        = hit_v;
        w_hit_base   = base_v;
    end

    // bits of the current row covered by [ptr, end)
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            w_mask[k] = (WORD_LOG'(k) >= r_ptr[WORD_LOG-1:0]) &&
                        ((w_end_row != w_ptr_row) || (WORD_LOG'(k) < r_end[WORD_LOG-1:0]));
        end
    end

    always_comb begin
        w_we    = i_cmd.clr_wr || i_cmd.mark_wr;
        w_waddr = i_cmd.clr_wr ? r_clr_row : w_ptr_row[RW-1:0];
        if (i_cmd.clr_wr) begin
            w_wdata = '0;
        end else if (r_val) begin
            w_wdata = w_rdata | w_mask;
        end else begin
            w_wdata = w_rdata & ~w_mask;
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_ptr_row[RW-1:0];
        priority if (i_cmd.scan_init) begin
            w_re    = 1'b1;
            w_raddr = w_lo_full[WORD_LOG +: RW];
        end else if (i_cmd.scan_step) begin
            // prefetch the next row during the last chunk of this one
            w_re    = w_chunk_last && !w_hit && (r_row != LAST_ROW);
            w_raddr = w_next_row[RW-1:0];
        end else if (i_cmd.mark_rd) begin
            w_re    = 1'b1;
            w_raddr = w_ptr_row[RW-1:0];
        end
    end

    ffba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_row <= r_clr_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_cmd   <= t_command'(i_command);
            r_size  <= i_size;
            r_lowp  <= i_low_priority;
            r_susp  <= i_suspended;
            r_fbase <= i_free_base;
        end

        if (i_cmd.rel_init) begin
            r_ptr       <= EW'(r_fbase);
            r_end       <= EW'(r_fbase) + EW'(r_size);
            r_val       <= 1'b0;
            r_res_grant <= 1'b1;
            r_res_base  <= '0;
        end

        if (i_cmd.scan_init) begin
            r_row   <= w_lo_full[EW-1:WORD_LOG];
            r_chunk <= '0;
            r_run   <= '0;
            r_start <= w_lo_full;
            r_lo    <= w_lo_full;
        end

        if (i_cmd.scan_step) begin
            if (w_hit) begin
                r_ptr       <= w_hit_base;
                r_end       <= w_hit_base + EW'(r_size);
                r_val       <= 1'b1;
                r_res_grant <= 1'b1;
                r_res_base  <= w_hit_base[BASE_W-1:0];
            end else begin
                r_run   <= w_run_next;
                r_start <= w_start_next;
                r_chunk <= r_chunk + CHUNK_LOG'(1);
                if (w_chunk_last) begin
                    r_row <= w_next_row;
                end
            end
        end

        if (i_cmd.mark_wr) begin
            // advance to the first unit of the next row
            r_ptr <= {w_ptr_row + PRW'(1), {WORD_LOG{1'b0}}};
        end

        if (i_cmd.res_grant) begin
            r_res_grant <= 1'b1;
            r_res_base  <= '0;
        end

        if (i_cmd.res_refuse) begin
            r_res_grant <= 1'b0;
            r_res_base  <= '0;
        end

        if (i_cmd.out_load) begin
            r_granted <= r_res_grant;
            r_base    <= r_res_base;
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.clr_last     = (r_clr_row == LAST_CLR);
        o_sts.is_release   = (r_cmd == CMD_RELEASE);
        o_sts.is_suspended = r_susp;
        o_sts.alloc_void   = (r_size == '0) || (w_lo_full >= POOL_E);
        o_sts.found        = w_hit;
        o_sts.scan_last    = w_chunk_last && (r_row == LAST_ROW);
        o_sts.mark_done    = (r_ptr >= r_end) || (w_ptr_row > LAST_ROW);
    end

    assign o_granted = r_granted;
    assign o_base    = r_base;

    `FFBA_ASSERT_IMPL(a_fit_in_window, i_clk, i_rst_n, i_cmd.scan_step && w_hit, (w_hit_base >= r_lo) && ((w_hit_base + EW'(r_size)) <= POOL_E), "found run lies outside the search window")
    `FFBA_ASSERT_IMPL(a_mark_in_range, i_clk, i_rst_n, i_cmd.mark_wr, (r_ptr < r_end) && (w_ptr_row <= LAST_ROW), "bitmap write outside the run")

endmodule

[rtl/core/first_fit_block_allocator_unit.sv]
// An allocate is decoded, then scans each 64-unit row one 8-unit chunk at a time up to the
// chunk where a run fits, marks the run row by row and closes; a scan that finds no run
// closes after its last row. A release is decoded, clears each 64-unit row it touches and
// closes; a suspended or refused allocate closes after decode. The result is valid the cycle
// after it is loaded. Throughput: one transaction in flight; next accepted once its result
// is registered. Reset (synchronous, active low) clears the bitmap RAM row by row.
`include "first_fit_block_allocator_unit_defines.svh"

module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int POOL_UNITS     = 1024,
    parameter int RESERVED_UNITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic               i_low_priority,
    input  logic               i_suspended,
    input  logic [FBASE_W-1:0] i_free_base,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_granted,
    output logic [BASE_W-1:0]  o_base
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffba_dpath #(
        .POOL_UNITS     (POOL_UNITS),
        .RESERVED_UNITS (RESERVED_UNITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_command      (i_command),
        .i_size         (i_size),
        .i_low_priority (i_low_priority),
        .i_suspended    (i_suspended),
        .i_free_base    (i_free_base),
        .o_granted      (o_granted),
        .o_base         (o_base)
    );

    `FFBA_ASSERT_IMPL(a_refused_base_zero, i_clk, i_rst_n, o_out_valid && !o_granted, o_base == '0, "refused transaction carries a nonzero base")

endmodule
